>>> sv/ven_pkg.sv
package ven_pkg;

    // Element and accumulator widths
    localparam int ELEM_BITS = 16;
    localparam int SQ_BITS   = 2 * ELEM_BITS;
    localparam int SUM_BITS  = 41;
    localparam int MAG_BITS  = 21;

    // Saturation ceiling of the running sum and the root it gives
    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
    localparam logic [MAG_BITS-1:0] MAG_AT_MAX = 21'd1482910;

    // Queue of finished sums between accumulator and root unit
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    // One finished vector: its sum of squares and the saturation flag
    typedef struct packed {
        logic                sat;
        logic [SUM_BITS-1:0] sum;
    } acc_result_t;

endpackage

>>> sv/ven_front.sv
module ven_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ven_pkg::ELEM_BITS-1:0]        s_tdata,
    input  logic                                 s_tlast,
    input  logic [ven_pkg::QCNT_BITS-1:0]        q_count,
    output logic                                 push,
    output ven_pkg::acc_result_t                 push_data
);

    logic                                 sq_valid_reg;
    logic                                 sq_last_reg;
    logic [ven_pkg::SQ_BITS-1:0]          sq_reg;
    logic [ven_pkg::SUM_BITS-1:0]         sum_reg;
    logic [ven_pkg::SUM_BITS-1:0]         sum_next;
    logic                                 ovf_reg;
    logic                                 ovf_next;
    logic                                 pending;
    logic                                 accept;
    logic [ven_pkg::ELEM_BITS-1:0]        abs_val;
    logic [ven_pkg::SUM_BITS:0]           sum_wide;
    logic                                 hit;

    // Keep room in the queue for every vector end still in flight
    assign pending  = sq_valid_reg & sq_last_reg;
    assign s_tready = (q_count + ven_pkg::QCNT_BITS'(pending))
                      < ven_pkg::QCNT_BITS'(ven_pkg::QDEPTH);
    assign accept   = s_tvalid & s_tready;

    // Magnitude of the element; the most negative value wraps to 2^(N-1)
    assign abs_val = s_tdata[ven_pkg::ELEM_BITS-1] ? (~s_tdata + 1'b1) : s_tdata;

    // Square stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else begin
            sq_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sq_reg      <= ven_pkg::SQ_BITS'(abs_val) * ven_pkg::SQ_BITS'(abs_val);
            sq_last_reg <= s_tlast;
        end
    end

    // Saturating add of the square
    assign sum_wide = {1'b0, sum_reg} + (ven_pkg::SUM_BITS+1)'(sq_reg);
    assign hit      = sum_wide >= {1'b0, ven_pkg::SUM_MAX};
    assign sum_next = hit ? ven_pkg::SUM_MAX : sum_wide[ven_pkg::SUM_BITS-1:0];
    assign ovf_next = ovf_reg | hit;

    // Hand the finished vector to the queue
    assign push          = pending;
    assign push_data.sum = sum_next;
    assign push_data.sat = ovf_next;

    // Accumulate, clear after the last element
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (sq_valid_reg) begin
            if (sq_last_reg) begin
                sum_reg <= '0;
                ovf_reg <= 1'b0;
            end else begin
                sum_reg <= sum_next;
                ovf_reg <= ovf_next;
            end
        end
    end

endmodule

>>> sv/ven_queue.sv
module ven_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push,
    input  ven_pkg::acc_result_t           push_data,
    input  logic                           pop,
    output logic                           not_empty,
    output ven_pkg::acc_result_t           head,
    output logic [ven_pkg::QCNT_BITS-1:0]  count
);

    ven_pkg::acc_result_t                  mem [ven_pkg::QDEPTH];
    logic [ven_pkg::QPTR_BITS-1:0]         wr_ptr_reg;
    logic [ven_pkg::QPTR_BITS-1:0]         rd_ptr_reg;
    logic [ven_pkg::QCNT_BITS-1:0]         count_reg;

    assign count     = count_reg;
    assign not_empty = count_reg != '0;
    assign head      = mem[rd_ptr_reg];

    // Store pushed entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> sv/ven_sqrt.sv
module ven_sqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  ven_pkg::acc_result_t           q_head,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ven_pkg::MAG_BITS-1:0]   mag,
    output logic                           sat
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                           state_reg;
    logic [ven_pkg::SUM_BITS-1:0]   rem_reg;
    logic [ven_pkg::SUM_BITS-1:0]   root_reg;
    logic [ven_pkg::SUM_BITS-1:0]   bit_reg;
    logic                           sat_run_reg;
    logic                           out_valid_reg;
    logic [ven_pkg::MAG_BITS-1:0]   mag_reg;
    logic                           sat_reg;
    logic [ven_pkg::SUM_BITS:0]     trial;
    logic                           fits;
    logic [ven_pkg::SUM_BITS-1:0]   rem_next;
    logic [ven_pkg::SUM_BITS-1:0]   root_next;
    logic                           last_step;
    logic                           out_free;
    logic                           step;

    assign m_tvalid = out_valid_reg;
    assign mag      = mag_reg;
    assign sat      = sat_reg;

    assign out_free  = !out_valid_reg || m_tready;
    assign pop       = (state_reg == ST_IDLE) && q_valid;
    assign last_step = bit_reg[0];
    assign step      = (state_reg == ST_RUN) && (!last_step || out_free);

    // One root digit per cycle while running; the last digit waits until the output register is free
    assign trial     = {1'b0, root_reg} + {1'b0, bit_reg};
    assign fits      = {1'b0, rem_reg} >= trial;
    assign rem_next  = fits ? (rem_reg - trial[ven_pkg::SUM_BITS-1:0]) : rem_reg;
    assign root_next = fits ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (step && last_step) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Load a sum, then shift through its digits
    always_ff @(posedge aclk) begin
        if (pop) begin
            rem_reg     <= q_head.sum;
            root_reg    <= '0;
            bit_reg     <= {1'b1, {(ven_pkg::SUM_BITS-1){1'b0}}};
            sat_run_reg <= q_head.sat;
        end else if (step) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            bit_reg  <= bit_reg >> 2;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && last_step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && last_step) begin
            mag_reg <= root_next[ven_pkg::MAG_BITS-1:0];
            sat_reg <= sat_run_reg;
        end
    end

endmodule

>>> sv/vector_euclidean_norm.sv
// Path: the last element of a vector is squared and registered, its finished sum
// is queued, then the root unit works out its digits and registers the result on m_tvalid.
// Throughput: one element per cycle while the queue has room; the root unit takes a
// new sum only once it is done with the last, with a four-deep queue of finished sums absorbing short vectors.
// Reset: aresetn is synchronous and active low; it clears the running sum,
// the saturation flag, the queue and the output valid.
module vector_euclidean_norm (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] element
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] magnitude, [23:21] zero
    output logic        m_tuser    // [0] saturated
);

    logic                                  q_push;
    ven_pkg::acc_result_t                  q_push_data;
    logic                                  q_pop;
    logic                                  q_not_empty;
    ven_pkg::acc_result_t                  q_head;
    logic [ven_pkg::QCNT_BITS-1:0]         q_count;
    logic [ven_pkg::MAG_BITS-1:0]          mag;

    ven_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_count   (q_count),
        .push      (q_push),
        .push_data (q_push_data)
    );

    ven_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head),
        .count     (q_count)
    );

    ven_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_head   (q_head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .mag      (mag),
        .sat      (m_tuser)
    );

    assign m_tdata = {(24 - ven_pkg::MAG_BITS)'(0), mag};

    // Queue never overflows
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_count != ven_pkg::QCNT_BITS'(ven_pkg::QDEPTH)))
        else $error("finished-sum queue overflow");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty)
        else $error("finished-sum queue underflow");

    // A saturated sum always yields the root of the ceiling
    a_sat_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (mag == ven_pkg::MAG_AT_MAX))
        else $error("saturated result with wrong magnitude");

endmodule

>>> dv/vector_euclidean_norm_tb.sv
`timescale 1ns / 1ps

module vector_euclidean_norm_tb;

    localparam int QUIET_TAIL  = 200;
    localparam int RANDOM_ITEMS = 360;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [ven_pkg::ELEM_BITS-1:0] element;
        logic                          last_element;
    } elem_item_t;

    typedef struct {
        logic [ven_pkg::MAG_BITS-1:0] magnitude;
        logic                         saturated;
    } norm_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [15:0] element
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [20:0] magnitude, [23:21] zero
    logic        m_tuser;          // [0] saturated

    elem_item_t   elem_pending[$];
    norm_result_t norm_expect_q[$];

    // Running state of the norm predictor
    logic [ven_pkg::SUM_BITS-1:0] norm_sum  = '0;
    logic                         norm_sat  = 1'b0;

    int src_gap  = 0;
    int sink_gap = 0;
    int mismatch_count = 0;

    vector_euclidean_norm DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Floor square root by trial of each root bit from the top down
    function automatic logic [63:0] floor_root(input logic [63:0] value);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int b = ven_pkg::MAG_BITS - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= value)
                root = trial;
        end
        return root;
    endfunction

    // Add the square of one element to the running sum; emit the norm on the last one
    task automatic accumulate_element(input elem_item_t item);
        logic [ven_pkg::ELEM_BITS-1:0] abs_val;
        logic [ven_pkg::SUM_BITS-1:0]  square;
        logic [ven_pkg::SUM_BITS-1:0]  headroom;
        norm_result_t                  res;
        abs_val  = item.element[ven_pkg::ELEM_BITS-1] ? -item.element : item.element;
        square   = ven_pkg::SUM_BITS'(abs_val) * ven_pkg::SUM_BITS'(abs_val);
        headroom = ven_pkg::SUM_MAX - norm_sum;
        if (square >= headroom) begin
            norm_sum = ven_pkg::SUM_MAX;
            norm_sat = 1'b1;
        end else begin
            norm_sum = norm_sum + square;
        end
        if (item.last_element) begin
            res.magnitude = ven_pkg::MAG_BITS'(floor_root(64'(norm_sum)));
            res.saturated = norm_sat;
            norm_expect_q.push_back(res);
            norm_sum = '0;
            norm_sat = 1'b0;
        end
    endtask

    task automatic queue_element(input logic [ven_pkg::ELEM_BITS-1:0] element,
                                 input logic last_element);
        elem_item_t item;
        item.element      = element;
        item.last_element = last_element;
        elem_pending.push_back(item);
    endtask

    function automatic logic [ven_pkg::ELEM_BITS-1:0] pick_element();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            3:       return 16'h0000;
            4:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // Source side: present pending items, with random idle bursts until the tail
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                accumulate_element(elem_pending.pop_front());
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (elem_pending.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (elem_pending.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                    src_gap  <= $urandom_range(0, 7);
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= elem_pending[0].element;
                    s_tlast  <= elem_pending[0].last_element;
                end
            end
        end
    end

    // Result side: check each accepted item against the oldest expected norm
    always @(posedge aclk) begin
        norm_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (norm_expect_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] unexpected result: magnitude=%0d saturated=%0b",
                                 $realtime, m_tdata[20:0], m_tuser);
                end else begin
                    want = norm_expect_q.pop_front();
                    if (m_tdata !== {3'b000, want.magnitude} || m_tuser !== want.saturated) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display(
                                "[%0t] mismatch: expected tdata=%06h sat=%0b, got tdata=%06h sat=%0b",
                                $realtime, {3'b000, want.magnitude}, want.saturated,
                                m_tdata, m_tuser);
                    end
                end
            end
            if (sink_gap != 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (elem_pending.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus, then drain and verdict
    initial begin
        int          issued;
        int          vec_len;

        // Single-element vectors at the extremes give the absolute value
        queue_element(16'h0000, 1'b1);
        queue_element(16'h8000, 1'b1);
        queue_element(16'h7fff, 1'b1);
        queue_element(16'hffff, 1'b1);
        queue_element(16'h0001, 1'b1);
        // Short vectors, mixed signs
        queue_element(16'd3, 1'b0);
        queue_element(16'd4, 1'b1);
        queue_element(-16'sd3, 1'b0);
        queue_element(-16'sd4, 1'b1);
        queue_element(16'h7fff, 1'b0);
        queue_element(16'h8000, 1'b0);
        queue_element(16'h5555, 1'b0);
        queue_element(16'haaaa, 1'b1);
        queue_element(16'h0000, 1'b0);
        queue_element(16'h0000, 1'b1);
        // Burst of singles to fill the root queue
        for (int i = 0; i < 8; i++)
            queue_element(pick_element(), 1'b1);

        // A 1024-element vector of the largest squares: a sum near the top root bits
        for (int i = 0; i < 1023; i++)
            queue_element(16'h8000, 1'b0);
        queue_element(16'h7fff, 1'b1);

        // Random vectors, mostly short
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0:       vec_len = $urandom_range(65, 300);
                1, 2, 3, 4, 5: vec_len = $urandom_range(13, 64);
                default: vec_len = $urandom_range(1, 12);
            endcase
            for (int i = 0; i < vec_len; i++)
                queue_element(pick_element(), i == vec_len - 1);
            issued += vec_len;
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (elem_pending.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (norm_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("vector_euclidean_norm regression: pass");
        else
            $display("vector_euclidean_norm regression: fail");
        $finish;
    end

    // Hang guard
    initial begin
        #5_000_000;
        $display("vector_euclidean_norm regression: fail");
        $finish;
    end

endmodule
